>>> sv/tdpt_pkg.sv
// Shared types and constants for the trial-division prime test.
// No dependencies; imported by tdpt_rem and the top level.
package tdpt_pkg;

  // Field width of the incoming number.
  localparam int NUMBER_BITS   = 31;
  // The divisor search starts here.
  localparam int FIRST_DIVISOR = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } tdpt_state_t;

  // Status reported by the remainder unit to the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

>>> sv/tdpt_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg for the status struct.
module tdpt_rem import tdpt_pkg::*; #(
  parameter int NW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output rem_sts_t      sts
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [NW-1:0] r_r, r_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   trial;

  assign trial = {r_r, q_r[NW-1]};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dividend;
      r_nxt   = '0;
      d_nxt   = divisor;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      // Shift in the next dividend bit and subtract when the divisor fits.
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        r_nxt = NW'(trial - {1'b0, d_r});
      end else begin
        r_nxt = trial[NW-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign sts.done = done_r;
  assign sts.zero = (r_r == '0);

endmodule

>>> sv/trial_division_prime_test.sv
// Top level of the trial-division prime test: sequencer and divisor registers.
// Depends on tdpt_pkg and tdpt_rem.
//
// A number is taken when start is high and busy is low; busy then stays high
// until the single result beat has gone out on out_valid / out_is_prime. The
// block tries divisors 2, 3, 4 and so on while the divisor squared does not
// exceed the number, and one shared bit-serial remainder unit does each test.
// Each divisor takes one check state and then one pass of the remainder unit, a
// quotient bit for each bit of the number width in use (31 at the default
// WIDTH), so a prime near 2^31 needs about 46340 passes.
// One and zero go straight to the done state and are answered not prime. The
// result is shown for a single cycle and the receiver cannot stall it.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [NUMBER_BITS-1:0] in_number,
  output logic                   out_valid,
  output logic                   out_is_prime
);

  // Bits of the number that survive the datapath width.
  localparam int NW  = (WIDTH < NUMBER_BITS) ? WIDTH : NUMBER_BITS;
  localparam int SQW = NW + 1;

  tdpt_state_t    state_r, state_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  div_r, div_nxt;
  logic [SQW-1:0] sq_r, sq_nxt;
  logic           verdict_r, verdict_nxt;
  logic           rem_start;
  rem_sts_t       rem_sts;
  logic           accept;
  logic           past_root;

  assign accept    = start && (state_r == ST_IDLE);
  assign past_root = (sq_r > {1'b0, num_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_number[NW-1:0] < NW'(FIRST_DIVISOR)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (past_root) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    rem_start = 1'b0;
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_CHECK: rem_start = !past_root;
      ST_DIV:   busy = 1'b1;
      ST_DONE:  out_valid = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign out_is_prime = verdict_r;

  // Divisor, running square and verdict.
  always_comb begin
    num_nxt     = num_r;
    div_nxt     = div_r;
    sq_nxt      = sq_r;
    verdict_nxt = verdict_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          num_nxt     = in_number[NW-1:0];
          div_nxt     = NW'(FIRST_DIVISOR);
          sq_nxt      = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
          verdict_nxt = 1'b0;
        end
      end
      ST_CHECK: begin
        if (past_root) begin
          verdict_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_sts.done && !rem_sts.zero) begin
          // (d + 1)^2 = d^2 + 2d + 1
          div_nxt = div_r + 1'b1;
          sq_nxt  = SQW'(sq_r + {div_r, 1'b1});
        end
      end
      default: verdict_nxt = verdict_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    num_r     <= num_nxt;
    div_r     <= div_nxt;
    sq_r      <= sq_nxt;
    verdict_r <= verdict_nxt;
  end

  tdpt_rem #(
    .NW (NW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (num_r),
    .divisor  (div_r),
    .sts      (rem_sts)
  );

endmodule

>>> sv/tdpt_chk.sv
// Port-level checks on the trial-division prime test, and the bind that attaches them.
// Depends only on the top level's ports.
module tdpt_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // An accepted beat keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting a number");

  // A result only appears while an item is in hand.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // Exactly one result beat, after which the block is free again.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat repeated or block stayed busy");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind trial_division_prime_test tdpt_chk u_tdpt_chk (.*);

>>> sim/trial_division_prime_test_test.sv
// Testbench for trial_division_prime_test: a short directed set, then random numbers
// that are mostly small, checked against an independent divisor-search predictor.
// Depends on tdpt_pkg and the block's RTL; needs no other file.
`timescale 1ns / 100ps

module trial_division_prime_test_test;
  import tdpt_pkg::*;

  localparam int RANDOM_NUMBERS = 100;
  localparam int SHOWN_ERRORS   = 10;

  typedef struct {
    bit [NUMBER_BITS-1:0] number;
    bit                   is_prime;
  } verdict_t;

  // Holds the verdicts still owed by the block and counts every disagreement.
  class prime_scoreboard;
    verdict_t        verdict_q[$];
    int              errors;
    longint unsigned held_number;
    longint unsigned stop_divisor;

    function new();
      errors       = 0;
      held_number  = 0;
      stop_divisor = FIRST_DIVISOR;
    endfunction

    // Divisor search on the held number; also leaves the divisor where it stopped.
    function bit prime_verdict();
      longint unsigned d;
      d = FIRST_DIVISOR;
      if (held_number < 2) begin
        stop_divisor = FIRST_DIVISOR;
        return 1'b0;
      end
      while (d * d <= held_number) begin
        if (held_number % d == 0) begin
          stop_divisor = d;
          return 1'b0;
        end
        d++;
      end
      stop_divisor = d;
      return 1'b1;
    endfunction

    function void record_error(string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void note_number(bit [NUMBER_BITS-1:0] number);
      verdict_t v;
      held_number = number;
      v.number    = number;
      v.is_prime  = prime_verdict();
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic got);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        record_error($sformatf("result beat with nothing outstanding, is_prime=%b", got));
        return;
      end
      v = verdict_q.pop_front();
      if (got !== v.is_prime)
        record_error($sformatf("number %0d: is_prime expected %b, got %b",
                               v.number, v.is_prime, got));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [NUMBER_BITS-1:0] in_number;
  logic                   out_valid;
  logic                   out_is_prime;

  prime_scoreboard sb;
  int              burst_left;

  trial_division_prime_test dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_number   (in_number),
    .out_valid   (out_valid),
    .out_is_prime(out_is_prime)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offers one number and returns once the block has taken the beat. Start is left
  // high after acceptance so that a back-to-back beat needs no second assignment.
  task automatic send_number(input bit [NUMBER_BITS-1:0] number);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(4, 10);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_number <= number;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_number(number);
  endtask

  // Mostly small numbers, since a prime costs one divisor pass per integer up to its
  // square root. Full-width values are forced to have a small factor.
  function automatic bit [NUMBER_BITS-1:0] draw_number();
    int unsigned r;
    int unsigned q;
    int unsigned k;
    case ($urandom_range(0, 4))
      0: r = $urandom_range(1, 1000);
      1: r = $urandom_range(1, 65535);
      2: r = $urandom_range(2, 400) * $urandom_range(2, 400);
      3: begin
        r = $urandom & 32'h7FFF_FFFF;
        k = $urandom_range(2, 7);
        r = r - r % k;
      end
      default: begin
        // Squares and their neighbours sit on the edge of the divisor bound.
        q = $urandom_range(2, 250);
        r = q * q + $urandom_range(0, 2) - 1;
      end
    endcase
    return r[NUMBER_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_is_prime);
  end

  initial begin
    int unsigned directed[];
    directed = '{
      0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 121, 1000, 7919, 10403, 65521, 65536,
      1048573, 1073741824, 1431655765, 715827882, 2147395600, 2147483646,
      2147483647
    };
    sb         = new();
    burst_left = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_number  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i][NUMBER_BITS-1:0]);
    repeat (RANDOM_NUMBERS) send_number(draw_number());
    start <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk);
    // Waiting on after the last verdict lets any stray strobe show up as an error.
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // The slowest run is set by the largest prime, whose search runs to its square
  // root, and this watchdog allows several times the whole expected run.
  initial begin
    #(64'd120_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> trial_division_prime_test.f
sv/tdpt_pkg.sv
sv/tdpt_rem.sv
sv/trial_division_prime_test.sv
sv/tdpt_chk.sv
sim/trial_division_prime_test_test.sv
